FILE: design/sms_pkg.sv
// Shared types for the stable merge sorter.
// Holds the element word type, the per-cell state and the cell control group.
// No dependencies.
package sms_pkg;

  localparam int unsigned DataWidth = 32;

  typedef logic signed [DataWidth-1:0] data_t;

  // One slot of the sorting row.
  typedef struct packed {
    logic  valid;
    data_t value;
  } slot_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic insert;  // place value_i into the sorted row
    logic drain;   // shift the row toward cell 0 by one slot
  } cell_ctl_t;

endpackage

FILE: design/sms_cell.sv
// One cell of the sorting row: holds a single element and its valid bit.
// Depends on sms_pkg for the slot and control types.
module sms_cell
  import sms_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  data_t     new_value_i,
  input  slot_t     left_i,
  input  logic      left_gt_i,
  input  slot_t     right_i,
  output slot_t     slot_o,
  output logic      gt_o
);

  logic  valid_q, valid_d;
  data_t value_q, value_d;

  // Insert before this slot when it is empty or holds a strictly larger key,
  // so equal keys keep their arrival order.
  assign gt_o   = !valid_q || (new_value_i < value_q);
  assign slot_o = '{valid: valid_q, value: value_q};

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctl_i.drain) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
    end else if (ctl_i.insert) begin
      if (left_gt_i) begin
        // make room: take the left neighbor's element
        valid_d = left_i.valid;
        value_d = left_i.value;
      end else if (gt_o) begin
        valid_d = 1'b1;
        value_d = new_value_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

FILE: design/stable_merge_sorter.sv
// Top level of the stable merge sorter: a row of sms_cell instances.
// Depends on sms_pkg and sms_cell.
//
// Usage:
//   Input channel: an element transfer happens at a rising edge with start_i
//   high and busy_o low. value_i is one signed element, last_i closes the set.
//   Each element is placed into a sorted row of DEPTH cells in the same cycle
//   it arrives. Elements that arrive while all DEPTH cells are filled are
//   dropped; a dropped element that carries last_i still closes the set.
//   Output channel: the cycle after the closing transfer, busy_o rises and
//   the row drains from cell 0, one result per cycle, marked by valid_o.
//   final_res_o is high with the largest element. busy_o falls after it.
//   Equal keys leave in arrival order.
//   The receiver cannot stall: results are shown for exactly one cycle.
//   Reset empties the row and returns the block to loading. No clearing pass
//   is needed; the valid bits of the cells clear at once.
module stable_merge_sorter
  import sms_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic signed [DataWidth-1:0] value_i,
  input  logic                        last_i,
  output logic                        valid_o,
  output logic signed [DataWidth-1:0] sorted_value_o,
  output logic                        final_res_o
);

  slot_t     slots [DEPTH];
  logic      gts   [DEPTH];
  cell_ctl_t ctl;
  logic      emit_q, emit_d;
  logic      accept;
  logic      full;

  assign accept = start_i && !emit_q;
  assign full   = slots[DEPTH-1].valid;

  assign ctl.insert = accept && !full;
  assign ctl.drain  = emit_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    slot_t left_slot;
    slot_t right_slot;
    logic  left_gt;

    if (i == 0) begin : g_first
      assign left_slot = '{valid: 1'b0, value: '0};
      assign left_gt   = 1'b0;
    end else begin : g_mid
      assign left_slot = slots[i-1];
      assign left_gt   = gts[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_slot = '{valid: 1'b0, value: '0};
    end else begin : g_inner
      assign right_slot = slots[i+1];
    end

    sms_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .new_value_i(value_i),
      .left_i     (left_slot),
      .left_gt_i  (left_gt),
      .right_i    (right_slot),
      .slot_o     (slots[i]),
      .gt_o       (gts[i])
    );
  end

  assign valid_o        = emit_q && slots[0].valid;
  assign sorted_value_o = slots[0].value;
  assign final_res_o    = valid_o && !slots[1].valid;

  always_comb begin
    emit_d = emit_q;
    if (emit_q) begin
      // stop once the last element leaves cell 0
      if (!slots[1].valid) begin
        emit_d = 1'b0;
      end
    end else if (accept && last_i) begin
      emit_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= 1'b0;
    end else begin
      emit_q <= emit_d;
    end
  end

  assign busy_o = emit_q;

endmodule

FILE: design/sms_checker.sv
// Port-level checks for the stable merge sorter, bound to the top level.
// Depends on stable_merge_sorter's port list only.
module sms_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic last_i,
  input logic valid_o,
  input logic final_res_o
);

  // results only while draining
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !valid_o)
    else $error("result strobe outside drain");

  // closing transfer starts the drain with a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_i) |=> (busy_o && valid_o))
    else $error("drain did not start after closing transfer");

  // results leave back to back until the final one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !final_res_o) |=> valid_o)
    else $error("gap in result stream");

  // block returns to loading right after the final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && final_res_o) |=> !busy_o)
    else $error("busy after final result");

  // no strobe while loading, so a busy drain always carries a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> valid_o)
    else $error("drain cycle without result");

endmodule

bind stable_merge_sorter sms_checker u_sms_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .last_i     (last_i),
  .valid_o    (valid_o),
  .final_res_o(final_res_o)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for stable_merge_sorter. It loads sets of signed elements, predicts the
// ascending output stream and checks every result transfer field by field.
// Depends on sms_pkg and the stable_merge_sorter RTL.
module testbench;
  import sms_pkg::*;

  localparam int unsigned DEPTH = 64;

  typedef enum int {
    FullRange,
    Clustered,
    Extremes,
    Ascending,
    Descending
  } pattern_e;

  typedef struct {
    data_t value;
    logic  last;
    int    gap;
  } elem_t;

  typedef struct {
    data_t value;
    logic  final_res;
  } sorted_t;

  logic  clk_i   = 1'b0;
  logic  rst_ni  = 1'b0;
  logic  start_i = 1'b0;
  data_t value_i = '0;
  logic  last_i  = 1'b0;
  logic  busy_o;
  logic  valid_o;
  data_t sorted_value_o;
  logic  final_res_o;

  elem_t   pending_q[$];
  data_t   open_set[$];
  sorted_t expected_sorted[$];
  logic    taken = 1'b0;
  bit      burst_mode;
  int      gap_left;
  int      mismatches;
  int      accepted;
  int      sets_closed;
  int      results_seen;

  stable_merge_sorter #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .value_i       (value_i),
    .last_i        (last_i),
    .valid_o       (valid_o),
    .sorted_value_o(sorted_value_o),
    .final_res_o   (final_res_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic queue_item(data_t v, logic last);
    elem_t e;
    int    roll;
    e.value = v;
    e.last  = last;
    roll    = $urandom_range(99);
    if (burst_mode || roll < 55) e.gap = 0;
    else if (roll < 85) e.gap = $urandom_range(3, 1);
    else if (roll < 96) e.gap = $urandom_range(10, 4);
    else e.gap = $urandom_range(60, 20);
    pending_q.push_back(e);
  endtask

  task automatic queue_set(int size, pattern_e pattern);
    data_t v;
    for (int i = 0; i < size; i++) begin
      case (pattern)
        FullRange: v = $urandom;
        Clustered: v = $signed($urandom_range(8)) - 4;
        Extremes: begin
          case ($urandom_range(4))
            0: v = data_t'(32'h8000_0000);
            1: v = data_t'(32'h7fff_ffff);
            2: v = '0;
            3: v = '1;
            default: v = $urandom;
          endcase
        end
        Ascending: v = i * 3 - 50;
        default: v = 1000 - i * 7;
      endcase
      queue_item(v, i == size - 1);
    end
  endtask

  // Hold the item until the transfer, then idle for its gap.
  always @(negedge clk_i) begin : drive
    elem_t nxt;
    if (rst_ni && (!start_i || taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (pending_q.size() != 0) begin
        nxt = pending_q.pop_front();
        start_i  <= 1'b1;
        value_i  <= nxt.value;
        last_i   <= nxt.last;
        gap_left = nxt.gap;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : watch
    sorted_t exp_r;
    int      pos;
    if (rst_ni) begin
      taken <= start_i && !busy_o;
      if (start_i && !busy_o) begin
        accepted++;
        // Keep the open set ordered; insert after equal keys to stay stable.
        if (open_set.size() < DEPTH) begin
          pos = open_set.size();
          while (pos > 0 && open_set[pos-1] > value_i) pos--;
          open_set.insert(pos, value_i);
        end
        if (last_i) begin
          foreach (open_set[k]) begin
            exp_r.value     = open_set[k];
            exp_r.final_res = (k == open_set.size() - 1);
            expected_sorted.push_back(exp_r);
          end
          open_set.delete();
          sets_closed++;
        end
      end
      if (valid_o === 1'b1) begin
        results_seen++;
        if (expected_sorted.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, actual value %0d final_res %0b",
                   $time, sorted_value_o, final_res_o);
        end else begin
          exp_r = expected_sorted.pop_front();
          if (sorted_value_o !== exp_r.value) begin
            mismatches++;
            $display("%0t: sorted_value expected %0d actual %0d",
                     $time, exp_r.value, sorted_value_o);
          end
          if (final_res_o !== exp_r.final_res) begin
            mismatches++;
            $display("%0t: final_res expected %0b actual %0b",
                     $time, exp_r.final_res, final_res_o);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int roll;
    int size;
    burst_mode = 1'b0;

    queue_item(data_t'(32'h7fff_ffff), 1'b1);
    queue_item(data_t'(32'h8000_0000), 1'b1);
    // Duplicates, both extremes, zero and minus one in one set.
    queue_item(5, 1'b0);
    queue_item(-3, 1'b0);
    queue_item(5, 1'b0);
    queue_item(data_t'(32'h8000_0000), 1'b0);
    queue_item(data_t'(32'h7fff_ffff), 1'b0);
    queue_item(0, 1'b0);
    queue_item(-1, 1'b0);
    queue_item(-3, 1'b1);
    queue_item(7, 1'b0);
    queue_item(7, 1'b1);
    queue_set(6, Descending);
    queue_set(5, Ascending);

    // Exactly full store, then a set that overflows and closes on a dropped element.
    queue_set(DEPTH, FullRange);
    burst_mode = 1'b1;
    queue_set(DEPTH + 1 + $urandom_range(5), Clustered);

    while (pending_q.size() < 270) begin
      burst_mode = ($urandom_range(4) == 0);
      roll = $urandom_range(99);
      if (roll < 80) size = $urandom_range(12, 1);
      else if (roll < 95) size = $urandom_range(40, 13);
      else size = $urandom_range(DEPTH + 4, DEPTH - 4);
      queue_set(size, pattern_e'($urandom_range(4)));
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_q.size() != 0 || start_i) @(posedge clk_i);
    while (expected_sorted.size() != 0) @(posedge clk_i);
    repeat (2 * DEPTH + 16) @(posedge clk_i);

    $display("Transferred %0d elements in %0d sets and checked %0d sorted results.",
             accepted, sets_closed, results_seen);
    $display("Sets ran from one element to past the %0d-entry store, with random gaps.",
             DEPTH);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #(3_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: stable_merge_sorter.f
design/sms_pkg.sv
design/sms_cell.sv
design/stable_merge_sorter.sv
design/sms_checker.sv
tb/sv/testbench.sv
